FILE: sv/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

  localparam int SLOTS      = 8;
  localparam int COUNT_BITS = 32;

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 4;
  localparam int RELOAD_W = 32;
  localparam int FIRE_W   = 8;
  localparam int GOT_W    = 4;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_ENABLE  = 2'd2,
    ACT_DISABLE = 2'd3
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [RELOAD_W-1:0] reload_value;
  } ptt_in_t;

  typedef struct packed {
    logic [FIRE_W-1:0] fire_mask;
    logic [GOT_W-1:0]  assigned_slot;
  } ptt_out_t;

  // Word that walks down the row of slot cells, one cell per cycle.
  typedef struct packed {
    logic                  go;
    action_t               act;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_BITS-1:0] reload;
    logic                  claim;
    logic [FIRE_W-1:0]     mask;
    logic [GOT_W-1:0]      got;
  } ptt_link_t;

endpackage

`default_nettype wire

FILE: sv/ptt_cell.sv
`default_nettype none

module ptt_cell
  import ptt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire ptt_link_t        link_i,
  output ptt_link_t             link_o
);

  logic                  alloc_r, alloc_nxt;
  logic                  en_r, en_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  ptt_link_t             link_r, link_nxt;
  logic                  fire;
  logic                  sel;

  assign sel = (CMP_W'(link_i.slot) == CMP_W'(cell_idx));

  always_comb begin
    alloc_nxt  = alloc_r;
    en_nxt     = en_r;
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    link_nxt   = link_i;
    fire       = 1'b0;
    if (link_i.go) begin
      case (link_i.act)
        ACT_TICK: begin
          if (alloc_r && en_r) begin
            if (cnt_r == reload_r) begin
              fire    = 1'b1;
              cnt_nxt = COUNT_BITS'(1);
            end else begin
              cnt_nxt = cnt_r + COUNT_BITS'(1);
            end
          end
        end
        ACT_ADD: begin
          // The first free cell the word reaches takes the new timer.
          if (link_i.claim && !alloc_r) begin
            alloc_nxt      = 1'b1;
            en_nxt         = 1'b1;
            cnt_nxt        = '0;
            reload_nxt     = link_i.reload;
            link_nxt.claim = 1'b0;
            link_nxt.got   = GOT_W'(cell_idx);
          end
        end
        ACT_ENABLE: begin
          if (sel) begin
            en_nxt = 1'b1;
          end
        end
        ACT_DISABLE: begin
          if (sel) begin
            en_nxt = 1'b0;
          end
        end
        default: begin
          en_nxt = en_r;
        end
      endcase
    end
    for (int b = 0; b < FIRE_W; b++) begin
      if (fire && (CMP_W'(b) == CMP_W'(cell_idx)) && (b < SLOTS)) begin
        link_nxt.mask[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r   <= 1'b0;
      en_r      <= 1'b0;
      link_r.go <= 1'b0;
    end else begin
      alloc_r <= alloc_nxt;
      en_r    <= en_nxt;
      link_r  <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    reload_r <= reload_nxt;
  end

  assign link_o = link_r;

endmodule

`default_nettype wire

FILE: sv/periodic_tick_timer_table.sv
// A result strobes once its word has been registered by every slot cell in turn.
// A new word is taken only while busy is low; the word walks the row of slot cells, one per cycle.
// busy is high from the accepting edge until the last cell has registered the word.
// Reset (synchronous, rst_n low) frees and disables every slot; no clearing pass is needed.
// The receiver cannot stall: out_valid is high for one cycle per word.
`default_nettype none

module periodic_tick_timer_table
  import ptt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire ptt_in_t  in_word,
  output logic          busy,
  output logic          out_valid,
  output ptt_out_t      out_word
);

  ptt_link_t links [SLOTS+1];
  logic      busy_r, busy_nxt;
  logic      take;

  assign take = start && !busy_r;

  always_comb begin
    links[0].go     = take;
    links[0].act    = action_t'(in_word.action);
    links[0].slot   = in_word.slot;
    links[0].reload = COUNT_BITS'(in_word.reload_value);
    links[0].claim  = (action_t'(in_word.action) == ACT_ADD);
    links[0].mask   = '0;
    links[0].got    = GOT_W'(SLOTS);
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ptt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(k)),
      .link_i   (links[k]),
      .link_o   (links[k+1])
    );
  end

  // The word is done once the last cell has registered it.
  always_comb begin
    busy_nxt = busy_r;
    if (take) begin
      busy_nxt = 1'b1;
    end
    if (links[SLOTS-1].go) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy                   = busy_r;
  assign out_valid              = links[SLOTS].go;
  assign out_word.fire_mask     = links[SLOTS].mask;
  assign out_word.assigned_slot = links[SLOTS].got;

endmodule

`default_nettype wire

FILE: sim/periodic_tick_timer_table_tb.sv
`timescale 1ns / 100ps

module periodic_tick_timer_table_tb
  import ptt_pkg::*;
;

  class timer_table_scoreboard;
    bit                    allocated [SLOTS];
    bit                    enabled   [SLOTS];
    bit [COUNT_BITS-1:0]   counter   [SLOTS];
    bit [COUNT_BITS-1:0]   period    [SLOTS];
    ptt_out_t              pending_reports [$];
    int                    mismatches;

    function new();
      foreach (allocated[k]) begin
        allocated[k] = 1'b0;
        enabled[k]   = 1'b0;
        counter[k]   = '0;
        period[k]    = '0;
      end
      mismatches = 0;
    endfunction

    // Advances the timer table by one accepted word and queues the report it should give.
    function void note_input(ptt_in_t w);
      ptt_out_t r;
      bit       claimed;
      r.fire_mask     = '0;
      r.assigned_slot = GOT_W'(SLOTS);
      claimed         = 1'b0;
      case (w.action)
        ACT_TICK: begin
          for (int k = 0; k < SLOTS; k++) begin
            if (allocated[k] && enabled[k]) begin
              if (counter[k] == period[k]) begin
                if (k < FIRE_W) r.fire_mask[k] = 1'b1;
                counter[k] = '0;
              end
              counter[k] = counter[k] + 1'b1;
            end
          end
        end
        ACT_ADD: begin
          for (int k = 0; k < SLOTS; k++) begin
            if (!claimed && !allocated[k]) begin
              claimed         = 1'b1;
              allocated[k]    = 1'b1;
              enabled[k]      = 1'b1;
              counter[k]      = '0;
              period[k]       = COUNT_BITS'(w.reload_value);
              r.assigned_slot = GOT_W'(k);
            end
          end
        end
        default: begin
          if (w.slot < SLOTS) enabled[w.slot] = (w.action == ACT_ENABLE);
        end
      endcase
      pending_reports.push_back(r);
    endfunction

    function void check_result(ptt_out_t got);
      ptt_out_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected: fire_mask=%h assigned_slot=%0d",
                   $realtime, got.fire_mask, got.assigned_slot);
        return;
      end
      want = pending_reports.pop_front();
      if (got.fire_mask !== want.fire_mask || got.assigned_slot !== want.assigned_slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: fire_mask exp=%h act=%h, assigned_slot exp=%0d act=%0d",
                   $realtime, want.fire_mask, got.fire_mask,
                   want.assigned_slot, got.assigned_slot);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  ptt_in_t  in_word;
  logic     busy;
  logic     out_valid;
  ptt_out_t out_word;

  timer_table_scoreboard sb = new();
  int idle_pct;

  periodic_tick_timer_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_input(in_word);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_word);
  end

  function automatic ptt_in_t make_word(logic [ACTION_W-1:0] act, int unsigned idx,
                                        logic [RELOAD_W-1:0] value);
    ptt_in_t w;
    w.action       = act;
    w.slot         = SLOT_W'(idx);
    w.reload_value = value;
    return w;
  endfunction

  // Mostly ticks so that the periods play out; enables and disables mostly hit real slots.
  function automatic ptt_in_t random_word();
    ptt_in_t w;
    int      pick;
    pick           = $urandom_range(99);
    w.reload_value = ($urandom_range(1) == 0) ? $urandom() : RELOAD_W'($urandom_range(15));
    w.slot         = ($urandom_range(3) == 0) ? SLOT_W'($urandom_range(15))
                                              : SLOT_W'($urandom_range(SLOTS - 1));
    if (pick < 68)      w.action = ACT_TICK;
    else if (pick < 78) w.action = ACT_ADD;
    else if (pick < 90) w.action = ACT_ENABLE;
    else                w.action = ACT_DISABLE;
    return w;
  endfunction

  // Holds start high until the word is taken; busy read at the edge is its pre-edge value.
  task automatic send_word(input ptt_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    start   <= 1'b0;
    in_word <= '0;
    rst_n   <= 1'b0;
    idle_pct = 18;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, then an enable of a free slot, which must not make it count.
    send_word(make_word(ACT_TICK, 0, '0));
    send_word(make_word(ACT_ENABLE, 3, '0));
    send_word(make_word(ACT_TICK, 0, '0));
    // Slot indexes past the table are ignored.
    send_word(make_word(ACT_ENABLE, SLOTS, '0));
    send_word(make_word(ACT_DISABLE, 15, '0));
    send_word(make_word(ACT_ENABLE, 12, 32'hFFFF_FFFF));
    // Fill the table; a reload of zero fires on its first tick only.
    send_word(make_word(ACT_ADD, 0, 32'h0000_0000));
    send_word(make_word(ACT_ADD, 15, 32'hFFFF_FFFF));
    send_word(make_word(ACT_ADD, 0, 32'd1));
    send_word(make_word(ACT_ADD, 0, 32'd2));
    send_word(make_word(ACT_ADD, 0, 32'd3));
    send_word(make_word(ACT_ADD, 0, 32'd5));
    send_word(make_word(ACT_ADD, 0, 32'd7));
    send_word(make_word(ACT_ADD, 0, 32'd12));
    // Table full: the add is refused.
    send_word(make_word(ACT_ADD, 0, 32'h5A5A_A5A5));
    send_word(make_word(ACT_TICK, 0, '0));
    send_word(make_word(ACT_TICK, 0, '0));
    send_word(make_word(ACT_DISABLE, 2, '0));
    send_word(make_word(ACT_TICK, 0, '0));
    send_word(make_word(ACT_TICK, 0, '0));
    send_word(make_word(ACT_ENABLE, 2, '0));
    send_word(make_word(ACT_TICK, 0, '0));
    send_word(make_word(ACT_TICK, 0, '0));

    send_random(443);
    idle_pct = 64;
    send_random(443);
    idle_pct = 0;
    send_random(443);
    start <= 1'b0;

    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
